>>> design/u8u32_pkg.sv
// Shared widths, byte-class masks and constants for the UTF-8 to UTF-32 stream decoder.
// No dependencies; imported by utf8_to_utf32_stream_decoder.
package u8u32_pkg;

	localparam int BYTE_W = 8;
	localparam int CP_W   = 21;
	localparam int CNT_W  = 24;
	localparam int PEND_W = 2;

	// continuation payload bits per trailing byte
	localparam int CONT_BITS = 6;

	localparam logic [CNT_W-1:0] LIMIT_RESET = {CNT_W{1'b1}};

	// byte classes
	localparam logic [BYTE_W-1:0] CONT_CLASS_MASK = 8'hC0;
	localparam logic [BYTE_W-1:0] CONT_CLASS_CODE = 8'h80;
	localparam logic [BYTE_W-1:0] ASCII_MASK      = 8'h7F;
	localparam logic [BYTE_W-1:0] CONT_MASK       = 8'h3F;
	localparam logic [BYTE_W-1:0] LEAD2_MASK      = 8'h1F;
	localparam logic [BYTE_W-1:0] LEAD3_MASK      = 8'h0F;
	localparam logic [BYTE_W-1:0] LEAD4_MASK      = 8'h07;

	// continuation bytes still expected after each lead form
	localparam logic [PEND_W-1:0] PEND_NONE  = 2'd0;
	localparam logic [PEND_W-1:0] PEND_ONE   = 2'd1;
	localparam logic [PEND_W-1:0] PEND_TWO   = 2'd2;
	localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

	// one result of the decoder
	typedef struct packed {
		logic [CP_W-1:0]  codepoint;
		logic             has_codepoint;
		logic             end_of_stream;
		logic [CNT_W-1:0] emitted_count;
	} result_t;

endpackage

>>> design/utf8_to_utf32_stream_decoder.sv
// UTF-8 to UTF-32 stream decoder, top level (single module).
// Depends on u8u32_pkg for widths, masks and the result struct.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one byte per transaction with
//   last_byte marking the end of a stream. Output channel (out_valid/out_ready)
//   carries at most one result per byte: a code point when a sequence completes,
//   and always one result for the last byte (end_of_stream, total count).
//   Bytes that complete nothing give no result. The write-only config channel
//   (cfg_valid/cfg_ready/cfg_data) sets output_limit; it is always ready. The user
//   must write it only while the decoder is idle; the decoder does not enforce this.
// Timing:
//   A byte lands in the input register and is decoded there against the partial
//   code point and pending count; its result is loaded into the output register
//   when that register is empty or its result is being taken, and out_valid then
//   rises if the byte gives a result.
//   One byte per cycle is sustained while the receiver does not stall; the pending
//   counter and partial value are updated as each byte is decoded.
// Reset clears the stream state, both stage valids, and sets output_limit to
// all ones. When the receiver stalls with a result waiting, the input register
// holds its byte and in_ready drops until the result is taken; nothing is lost.
module utf8_to_utf32_stream_decoder (
	input  logic                             clk,
	input  logic                             arst_n,
	// byte input
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [u8u32_pkg::BYTE_W-1:0]     data_byte,
	input  logic                             last_byte,
	// result output
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [u8u32_pkg::CP_W-1:0]       codepoint,
	output logic                             has_codepoint,
	output logic                             end_of_stream,
	output logic [u8u32_pkg::CNT_W-1:0]      emitted_count,
	// configuration write
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [u8u32_pkg::CNT_W-1:0]      cfg_data
);
	import u8u32_pkg::*;

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                last_s1;

	logic [CNT_W-1:0]    limit_q;
	logic [CP_W-1:0]     part_q;
	logic [PEND_W-1:0]   pend_q;
	logic [CNT_W-1:0]    total_q;

	logic                out_valid_q;
	result_t             result_q;

	logic                process;
	logic                emit;
	logic [CP_W-1:0]     cp;
	logic [CP_W-1:0]     nxt_part;
	logic [PEND_W-1:0]   nxt_pend;
	logic [CNT_W-1:0]    nxt_total;
	logic [CP_W-1:0]     shifted;
	result_t             result_d;

	// handshakes
	assign process   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready  = !valid_s1 || process;
	assign cfg_ready = 1'b1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// decode: continuation, broken sequence or new lead
	assign shifted = {part_q[CP_W-CONT_BITS-1:0], byte_s1[CONT_BITS-1:0]};

	always_comb begin
		nxt_part = part_q;
		nxt_pend = pend_q;
		emit     = 1'b0;
		cp       = '0;
		if (total_q < limit_q) begin
			if (pend_q != PEND_NONE &&
			    (byte_s1 & CONT_CLASS_MASK) == CONT_CLASS_CODE) begin
				nxt_part = shifted;
				nxt_pend = pend_q - PEND_ONE;
				if (pend_q == PEND_ONE) begin
					cp       = shifted;
					nxt_part = '0;
					emit     = 1'b1;
				end
			end else begin
				// a broken sequence is dropped, the byte is looked at as a lead
				nxt_part = '0;
				nxt_pend = PEND_NONE;
				case (byte_s1) inside
					8'b0???????: begin
						cp   = CP_W'(byte_s1 & ASCII_MASK);
						emit = 1'b1;
					end
					8'b110?????: begin
						nxt_part = CP_W'(byte_s1 & LEAD2_MASK);
						nxt_pend = PEND_ONE;
					end
					8'b1110????: begin
						nxt_part = CP_W'(byte_s1 & LEAD3_MASK);
						nxt_pend = PEND_TWO;
					end
					8'b11110???: begin
						nxt_part = CP_W'(byte_s1 & LEAD4_MASK);
						nxt_pend = PEND_THREE;
					end
					default: begin
						// stray continuation or invalid lead: skipped
						nxt_part = '0;
					end
				endcase
			end
		end else begin
			// limit reached: byte ignored, pending sequence dropped
			nxt_part = '0;
			nxt_pend = PEND_NONE;
		end
		nxt_total = total_q + CNT_W'(emit);
	end

	always_comb begin
		result_d.codepoint     = cp;
		result_d.has_codepoint = emit;
		result_d.end_of_stream = last_s1;
		result_d.emitted_count = nxt_total;
	end

	// stream state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			part_q  <= '0;
			pend_q  <= PEND_NONE;
			total_q <= '0;
		end else if (process) begin
			if (last_s1) begin
				part_q  <= '0;
				pend_q  <= PEND_NONE;
				total_q <= '0;
			end else begin
				part_q  <= nxt_part;
				pend_q  <= nxt_pend;
				total_q <= nxt_total;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (process) begin
			out_valid_q <= emit || last_s1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (process) begin
			result_q <= result_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign codepoint     = result_q.codepoint;
	assign has_codepoint = result_q.has_codepoint;
	assign end_of_stream = result_q.end_of_stream;
	assign emitted_count = result_q.emitted_count;

	// checks
	a_part_idle: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == PEND_NONE |-> part_q == '0)
		else $error("partial value left over with nothing pending");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		process && last_s1 |=> total_q == '0 && pend_q == PEND_NONE)
		else $error("stream state not cleared after last byte");

	a_no_empty_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_q.has_codepoint |-> result_q.end_of_stream)
		else $error("result with neither code point nor end of stream");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && result_q.has_codepoint |-> result_q.emitted_count != '0)
		else $error("code point emitted with zero count");

	a_blank_cp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_q.has_codepoint |-> result_q.codepoint == '0)
		else $error("code point field not zero on end-only result");

endmodule
